@@ src/assert_macros.svh @@
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSFL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TSFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/tsfl_pkg.sv @@
`default_nettype none

package tsfl_pkg;

    localparam int COORD_BITS_DEF   = 16;
    localparam int MAX_VIEWPORT_DEF = 4096;

    localparam int VP_W      = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 15;
    localparam int DEPTH_W   = 16;
    localparam int INTEN_W   = 16;

    // output tdata layout
    localparam int VTX_OUT_W  = 2 * PIX_W + DEPTH_W;
    localparam int INTEN_LSB  = 3 * VTX_OUT_W;
    localparam int OUT_FLD_W  = INTEN_LSB + INTEN_W;
    localparam int OUT_TD_W   = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [32:0] ONE_Q30 = 33'd1073741824;
    localparam logic [32:0] EPS_Q30 = 33'd107;

    // projected quotient bits kept before saturation
    localparam int PROJ_Q_W = 31;

    localparam int VTX_LAT = 37;
    localparam int LIT_LAT = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEWPORT_WIDTH  = 3'd0,
        CFG_VIEWPORT_HEIGHT = 3'd1,
        CFG_LIGHT_X         = 3'd2,
        CFG_LIGHT_Y         = 3'd3,
        CFG_LIGHT_Z         = 3'd4,
        CFG_PROJ_ENABLE     = 3'd5,
        CFG_INV_DISTANCE    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic        proj_en;
        logic [15:0] inv_dist;
    } vtx_cfg_t;

    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
    } lit_cfg_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } div_flags_t;

endpackage

`default_nettype wire

@@ src/triangle_setup_flat_lighting.sv @@
`default_nettype none

// Triangle setup with flat lighting.
// s_* : one triangle per transfer, nine vertex coordinates in s_tdata.
// m_* : one result per triangle: screen x/y and depth per vertex, then the
//       flat intensity in m_tdata; the visible flag in m_tuser.
// cfg_* : register writes (viewport, light direction, projection), taken at
//       any edge with cfg_we high; write only while the block is drained.
// Throughput: one triangle per cycle, fully pipelined, while no stall holds it.
// Pipeline: the lighting lane is the longest path: 8 setup stages, a 31-stage
//   square root, a 16-stage divider and a result stage, the first loading at
//   the transfer edge; the vertex lanes (37 stages, mostly the 32-stage
//   perspective divider) are delayed to line up, then one output register
//   merges them.
// Stall: when m_tvalid is held without m_tready and a result is waiting
//   behind it, the whole pipeline freezes and s_tready drops; bubbles still
//   close up behind a held result.
// Reset: rst_n clears the pipeline valid bits and the output valid, and
//   loads the register defaults (1024 x 1024 viewport, light toward -z,
//   projection off, camera distance 3). No clearing pass is needed.
module triangle_setup_flat_lighting
    import tsfl_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int MAX_VIEWPORT = MAX_VIEWPORT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // a_x a_y a_z b_x b_y b_z c_x c_y c_z, COORD_BITS each, zero padded
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sa_x sa_y sa_depth sb_x sb_y sb_depth sc_x sc_y sc_depth intensity, padded
    output logic [OUT_TD_W-1:0]                  m_tdata,
    // visible
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_we,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_W-1:0]                     cfg_data
);

    localparam int SIZE_W = $clog2(MAX_VIEWPORT + 1);
    localparam int CMP_W  = (SIZE_W > VP_W) ? SIZE_W : VP_W;
    localparam int DLY    = LIT_LAT - VTX_LAT;

    // ---------------- configuration registers ----------------
    logic [VP_W-1:0]    vp_w_reg, vp_h_reg;
    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg;
    logic               proj_en_reg;
    logic [15:0]        inv_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg     <= 13'd1024;
            vp_h_reg     <= 13'd1024;
            light_x_reg  <= '0;
            light_y_reg  <= '0;
            light_z_reg  <= -16'sd16384;
            proj_en_reg  <= 1'b0;
            inv_dist_reg <= 16'd21845;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VIEWPORT_WIDTH:  vp_w_reg     <= cfg_data[VP_W-1:0];
                CFG_VIEWPORT_HEIGHT: vp_h_reg     <= cfg_data[VP_W-1:0];
                CFG_LIGHT_X:         light_x_reg  <= $signed(cfg_data);
                CFG_LIGHT_Y:         light_y_reg  <= $signed(cfg_data);
                CFG_LIGHT_Z:         light_z_reg  <= $signed(cfg_data);
                CFG_PROJ_ENABLE:     proj_en_reg  <= cfg_data[0];
                CFG_INV_DISTANCE:    inv_dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // viewport sizes clamp to the largest supported image
    logic [CMP_W-1:0]  vw_ext, vh_ext, vw_eff, vh_eff;
    logic [SIZE_W-1:0] size_x, size_y;

    assign vw_ext = CMP_W'(vp_w_reg);
    assign vh_ext = CMP_W'(vp_h_reg);
    assign vw_eff = (vw_ext > CMP_W'(MAX_VIEWPORT)) ? CMP_W'(MAX_VIEWPORT) : vw_ext;
    assign vh_eff = (vh_ext > CMP_W'(MAX_VIEWPORT)) ? CMP_W'(MAX_VIEWPORT) : vh_ext;
    assign size_x = SIZE_W'(vw_eff);
    assign size_y = SIZE_W'(vh_eff);

    vtx_cfg_t vcfg;
    lit_cfg_t lcfg;
    assign vcfg.proj_en  = proj_en_reg;
    assign vcfg.inv_dist = inv_dist_reg;
    assign lcfg.light_x  = light_x_reg;
    assign lcfg.light_y  = light_y_reg;
    assign lcfg.light_z  = light_z_reg;

    // ---------------- flow control ----------------
    logic [LIT_LAT-1:0] vld_reg;
    logic               m_tvalid_reg;
    logic               adv;

    // freeze only when a finished result would run into a held output
    assign adv      = !(m_tvalid_reg && !m_tready && vld_reg[LIT_LAT-1]);
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LIT_LAT-2:0], s_tvalid};
    end

    // ---------------- input unpack to Q2.14 ----------------
    logic signed [15:0] vq [0:8];

    for (genvar k = 0; k < 9; k++)
    begin : g_unpack
        logic signed [COORD_BITS-1:0] raw;
        assign raw = $signed(s_tdata[k*COORD_BITS +: COORD_BITS]);
        if (COORD_BITS > 16)
        begin : g_down
            logic signed [COORD_BITS-1:0] shr;
            assign shr   = raw >>> (COORD_BITS - 16);
            assign vq[k] = $signed(shr[15:0]);
        end
        else if (COORD_BITS == 16)
        begin : g_same
            assign vq[k] = raw;
        end
        else
        begin : g_up
            assign vq[k] = $signed({raw, {(16 - COORD_BITS){1'b0}}});
        end
    end

    // ---------------- lanes ----------------
    logic [VTX_OUT_W-1:0] lane_out [0:2];

    for (genvar v = 0; v < 3; v++)
    begin : g_vtx
        logic signed [PIX_W-1:0]   px, py;
        logic signed [DEPTH_W-1:0] dz;

        tsfl_vertex_lane #(
            .SIZE_W (SIZE_W)
        ) u_lane (
            .clk    (clk),
            .en     (adv),
            .x      (vq[3*v]),
            .y      (vq[3*v+1]),
            .z      (vq[3*v+2]),
            .cfg    (vcfg),
            .size_x (size_x),
            .size_y (size_y),
            .px     (px),
            .py     (py),
            .depth  (dz)
        );

        assign lane_out[v] = {dz, py, px};
    end

    logic signed [INTEN_W-1:0] inten;

    tsfl_light_lane u_light (
        .clk       (clk),
        .en        (adv),
        .vtx       (vq),
        .cfg       (lcfg),
        .intensity (inten)
    );

    // vertex results wait for the longer lighting lane
    logic [INTEN_LSB-1:0] dly_reg [0:DLY-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0] <= {lane_out[2], lane_out[1], lane_out[0]};
            for (int i = 1; i < DLY; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    // ---------------- merge / output register ----------------
    logic [OUT_TD_W-1:0] m_tdata_reg;
    logic                vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (!m_tvalid_reg || m_tready)
            m_tvalid_reg <= vld_reg[LIT_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (!m_tvalid_reg || m_tready)
        begin
            m_tdata_reg <= OUT_TD_W'({inten, dly_reg[DLY-1]});
            vis_reg     <= !inten[INTEN_W-1] && (inten != '0);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = vis_reg;

endmodule

`default_nettype wire

@@ src/tsfl_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, saturation flag.
module tsfl_div
    import tsfl_pkg::*;
#(
    parameter int NUM_W = 46,
    parameter int DEN_W = 32,
    parameter int Q_W   = 31
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    output logic [Q_W-1:0]   quo,
    output div_flags_t       flags
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [W-1:0]   rem_reg [0:Q_W-1];
    logic [W-1:0]   den_reg [0:Q_W-1];
    logic [Q_W-1:0] quo_reg [0:Q_W];
    div_flags_t     flg_reg [0:Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]       <= W'(num);
            den_reg[0]       <= W'(den);
            quo_reg[0]       <= '0;
            flg_reg[0].neg   <= neg;
            flg_reg[0].zero  <= (num == '0);
            flg_reg[0].ovf   <= (W'(num) >= (W'(den) << Q_W));
        end
    end

    for (genvar i = 1; i <= Q_W; i++)
    begin : g_stage
        localparam int B = Q_W - i;
        logic [W-1:0] trial;
        logic         fits;

        assign trial = den_reg[i-1] << B;
        assign fits  = (rem_reg[i-1] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= quo_reg[i-1] | (fits ? (Q_W'(1) << B) : '0);
                flg_reg[i] <= flg_reg[i-1];
            end
        end

        if (i < Q_W)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= fits ? rem_reg[i-1] - trial : rem_reg[i-1];
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end
    end

    assign quo   = quo_reg[Q_W];
    assign flags = flg_reg[Q_W];

endmodule

`default_nettype wire

@@ src/tsfl_vertex_lane.sv @@
`default_nettype none

// One vertex: perspective divide, depth saturation, viewport mapping.
module tsfl_vertex_lane
    import tsfl_pkg::*;
#(
    parameter int SIZE_W = 13
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [15:0]        x,
    input  logic signed [15:0]        y,
    input  logic signed [15:0]        z,
    input  vtx_cfg_t                  cfg,
    input  logic        [SIZE_W-1:0]  size_x,
    input  logic        [SIZE_W-1:0]  size_y,
    output logic signed [PIX_W-1:0]   px,
    output logic signed [PIX_W-1:0]   py,
    output logic signed [DEPTH_W-1:0] depth
);

    localparam int TW = 32 + SIZE_W + 1;

    localparam logic signed [TW:0] PIX_MAX = (TW+1)'(16383);
    localparam logic signed [TW:0] PIX_MIN = (TW+1)'(-16384);

    function automatic logic [15:0] mag16(input logic [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 16'(-e) : v;
    endfunction

    function automatic logic signed [31:0] clamp_u(input logic signed [32:0] q);
        logic signed [33:0] u;
        u = 34'(q) + 34'sd16384;
        if (u > 34'sd1073741824)
            return 32'sd1073741824;
        else if (u < -34'sd1073741824)
            return -32'sd1073741824;
        else
            return $signed(u[31:0]);
    endfunction

    function automatic logic signed [15:0] sat_depth(input logic signed [32:0] q);
        if (q > 33'sd32767)
            return 16'sh7fff;
        else if (q < -33'sd32768)
            return -16'sh8000;
        else
            return $signed(q[15:0]);
    endfunction

    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [TW-1:0] t);
        logic signed [TW:0] r;
        r = ($signed({t[TW-1], t}) + $signed((TW+1)'(16384))) >>> 15;
        if (r > PIX_MAX)
            return 15'sh3fff;
        else if (r < PIX_MIN)
            return -15'sh4000;
        else
            return $signed(r[PIX_W-1:0]);
    endfunction

    // stage A: z * inv_distance
    logic signed [15:0] ca_reg [0:2];
    logic signed [32:0] zp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg[0] <= x;
            ca_reg[1] <= y;
            ca_reg[2] <= z;
            zp_reg    <= z * $signed({1'b0, cfg.inv_dist});
        end
    end

    // stage B: w in Q2.30
    logic signed [15:0] cb_reg [0:2];
    logic signed [32:0] w_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg <= ca_reg;
            w_reg  <= cfg.proj_en ? $signed(ONE_Q30 + EPS_Q30) - zp_reg
                                  : $signed(ONE_Q30);
        end
    end

    logic [31:0] w_mag;
    assign w_mag = w_reg[32] ? 32'(-w_reg) : 32'(w_reg);

    logic [PROJ_Q_W-1:0] quo [0:2];
    div_flags_t          flg [0:2];
    logic signed [32:0]  q   [0:2];

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        logic [45:0] num;
        logic [32:0] qm;

        assign num = {mag16(cb_reg[k]), 30'd0};

        tsfl_div #(
            .NUM_W (46),
            .DEN_W (32),
            .Q_W   (PROJ_Q_W)
        ) u_div (
            .clk   (clk),
            .en    (en),
            .num   (num),
            .den   (w_mag),
            .neg   (cb_reg[k][15] ^ w_reg[32]),
            .quo   (quo[k]),
            .flags (flg[k])
        );

        // overflow stands for any magnitude that later saturates anyway
        assign qm   = flg[k].zero ? '0 :
                      (flg[k].ovf ? (33'd1 << PROJ_Q_W) : 33'(quo[k]));
        assign q[k] = flg[k].neg ? $signed(-qm) : $signed(qm);
    end

    // P1: offset and clamp, depth saturation
    logic signed [31:0] ux_reg, uy_reg;
    logic signed [15:0] d1_reg, d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= clamp_u(q[0]);
            uy_reg <= clamp_u(q[1]);
            d1_reg <= sat_depth(q[2]);
        end
    end

    // P2: scale by viewport size
    logic signed [TW-1:0] tx_reg, ty_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg <= ux_reg * $signed({1'b0, size_x});
            ty_reg <= uy_reg * $signed({1'b0, size_y});
            d2_reg <= d1_reg;
        end
    end

    // P3: round, halve, saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px    <= to_pix(tx_reg);
            py    <= to_pix(ty_reg);
            depth <= d2_reg;
        end
    end

endmodule

`default_nettype wire

@@ src/tsfl_light_lane.sv @@
`default_nettype none

// Flat lighting: edge cross product, normalize, isqrt, divide.
module tsfl_light_lane
    import tsfl_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [15:0]        vtx [0:8],
    input  lit_cfg_t                  cfg,
    output logic signed [INTEN_W-1:0] intensity
);

    // L1: edges ab, ac
    logic signed [16:0] e_reg [0:5];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i]     <= 17'(vtx[3+i]) - 17'(vtx[i]);
                e_reg[3 + i] <= 17'(vtx[6+i]) - 17'(vtx[i]);
            end
        end
    end

    // L2: cross product terms
    logic signed [33:0] p_reg [0:5];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= e_reg[1] * e_reg[5];
            p_reg[1] <= e_reg[2] * e_reg[4];
            p_reg[2] <= e_reg[2] * e_reg[3];
            p_reg[3] <= e_reg[0] * e_reg[5];
            p_reg[4] <= e_reg[0] * e_reg[4];
            p_reg[5] <= e_reg[1] * e_reg[3];
        end
    end

    // L3: normal
    logic signed [34:0] n_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= 35'(p_reg[2*i]) - 35'(p_reg[2*i+1]);
        end
    end

    // L4: largest magnitude
    logic        [34:0] m_reg;
    logic signed [34:0] n4_reg [0:2];
    logic        [34:0] a4 [0:2];
    logic        [34:0] m01;

    for (genvar i = 0; i < 3; i++)
    begin : g_abs
        assign a4[i] = n_reg[i][34] ? 35'(-n_reg[i]) : 35'(n_reg[i]);
    end
    assign m01 = (a4[0] > a4[1]) ? a4[0] : a4[1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg  <= (m01 > a4[2]) ? m01 : a4[2];
            n4_reg <= n_reg;
        end
    end

    // L5: leading one position
    logic        [5:0]  pos_reg;
    logic signed [34:0] n5_reg [0:2];
    logic        [5:0]  pos;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < 35; i++)
            if (m_reg[i])
                pos = 6'(i);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos;
            n5_reg  <= n4_reg;
        end
    end

    // L6: bring the largest component to [2^29, 2^30)
    logic signed [30:0] nn_reg [0:2];
    logic signed [34:0] sh [0:2];

    for (genvar i = 0; i < 3; i++)
    begin : g_norm
        assign sh[i] = (pos_reg >= 6'd29) ? (n5_reg[i] >>> (pos_reg - 6'd29))
                                          : (n5_reg[i] <<< (6'd29 - pos_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                nn_reg[i] <= $signed(sh[i][30:0]);
        end
    end

    // L7: squares and light products
    logic signed [61:0] sq_reg  [0:2];
    logic signed [46:0] dot_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= nn_reg[i] * nn_reg[i];
            dot_reg[0] <= nn_reg[0] * cfg.light_x;
            dot_reg[1] <= nn_reg[1] * cfg.light_y;
            dot_reg[2] <= nn_reg[2] * cfg.light_z;
        end
    end

    // L8: sums
    logic        [61:0] sum_reg;
    logic signed [48:0] d8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            d8_reg  <= -(49'(dot_reg[0]) + 49'(dot_reg[1]) + 49'(dot_reg[2]));
        end
    end

    // integer square root, one result bit per stage
    localparam int SQ_STEPS = 31;
    logic        [62:0] sx [0:SQ_STEPS];
    logic        [62:0] sr [0:SQ_STEPS];
    logic signed [48:0] sd [0:SQ_STEPS];

    assign sx[0] = 63'(sum_reg);
    assign sr[0] = '0;
    assign sd[0] = d8_reg;

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [62:0] bitv;
        logic [62:0] trial;
        logic [62:0] x_reg, r_reg;
        logic signed [48:0] d_reg;

        assign bitv  = 63'(1) << (60 - 2 * j);
        assign trial = sr[j] + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sx[j] >= trial)
                begin
                    x_reg <= sx[j] - trial;
                    r_reg <= (sr[j] >> 1) + bitv;
                end
                else
                begin
                    x_reg <= sx[j];
                    r_reg <= sr[j] >> 1;
                end
                d_reg <= sd[j];
            end
        end

        assign sx[j+1] = x_reg;
        assign sr[j+1] = r_reg;
        assign sd[j+1] = d_reg;
    end

    // 2d / root, saturating to 16 bits
    logic [48:0]  d_mag;
    logic [49:0]  num;
    logic [14:0]  quo;
    div_flags_t   flg;

    assign d_mag = sd[SQ_STEPS][48] ? 49'(-sd[SQ_STEPS]) : 49'(sd[SQ_STEPS]);
    assign num   = {d_mag, 1'b0};

    tsfl_div #(
        .NUM_W (50),
        .DEN_W (31),
        .Q_W   (15)
    ) u_div (
        .clk   (clk),
        .en    (en),
        .num   (num),
        .den   (sr[SQ_STEPS][30:0]),
        .neg   (sd[SQ_STEPS][48]),
        .quo   (quo),
        .flags (flg)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flg.zero)
                intensity <= '0;
            else if (flg.ovf)
                intensity <= flg.neg ? -16'sh8000 : 16'sh7fff;
            else
                intensity <= flg.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
    end

endmodule

`default_nettype wire

@@ src/tsfl_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module tsfl_checker
    import tsfl_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tready,
    input  wire                m_tvalid,
    input  wire                m_tready,
    input  wire [OUT_TD_W-1:0] m_tdata,
    input  wire [0:0]          m_tuser
);

    logic inten_pos;
    assign inten_pos = !m_tdata[INTEN_LSB+INTEN_W-1]
                       && (m_tdata[INTEN_LSB +: INTEN_W] != '0);

    // held result stays put
    `TSFL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // visible flag agrees with the intensity sign
    `TSFL_ASSERT_IMPL(a_visible, clk, rst_n, m_tvalid, m_tuser[0] == inten_pos)

    // input side only stalls behind a held result
    `TSFL_ASSERT_IMPL(a_ready, clk, rst_n, !m_tvalid || m_tready, s_tready)

    // nothing comes out right after reset
    `TSFL_ASSERT_IMPL(a_reset_empty, clk, rst_n, $rose(rst_n), !m_tvalid)

endmodule

bind triangle_setup_flat_lighting tsfl_checker u_tsfl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/tb_triangle_setup_flat_lighting.sv @@
`timescale 1ns / 100ps

// Expected-result store and checker for the triangle setup block.
class tri_setup_scoreboard;
    // packed result: {visible, m_tdata fields}
    logic [176:0] pending[$];
    int           errors;

    // camera and light settings, a copy of the block's registers
    logic [12:0]        vp_w;
    logic [12:0]        vp_h;
    logic signed [15:0] lx, ly, lz;
    logic               proj_en;
    logic [15:0]        inv_dist;

    function new();
        errors   = 0;
        vp_w     = 13'd1024;
        vp_h     = 13'd1024;
        lx       = 16'sd0;
        ly       = 16'sd0;
        lz       = -16'sd16384;
        proj_en  = 1'b0;
        inv_dist = 16'd21845;
    endfunction

    function void write_reg(tsfl_pkg::cfg_idx_t idx, logic [15:0] val);
        case (idx)
            tsfl_pkg::CFG_VIEWPORT_WIDTH:  vp_w = val[12:0];
            tsfl_pkg::CFG_VIEWPORT_HEIGHT: vp_h = val[12:0];
            tsfl_pkg::CFG_LIGHT_X:         lx = val;
            tsfl_pkg::CFG_LIGHT_Y:         ly = val;
            tsfl_pkg::CFG_LIGHT_Z:         lz = val;
            tsfl_pkg::CFG_PROJ_ENABLE:     proj_en = val[0];
            tsfl_pkg::CFG_INV_DISTANCE:    inv_dist = val;
            default: ;
        endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor shift for signed values
    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint perspective(longint c, longint w);
        longint lim;
        lim = 64'sd1099511627776;
        if (w == 0)
            return c > 0 ? lim : (c < 0 ? -lim : 0);
        return clamp((c * 64'sd1073741824) / w, -lim, lim);
    endfunction

    static function logic [14:0] pixel(longint v, longint size);
        longint t;
        t = (v + 16384) * size;
        return 15'(clamp(floor_shr(t + 16384, 15), -16384, 16383));
    endfunction

    static function longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function longint shade(longint v[9]);
        longint n[3];
        longint m, a, root, d;
        longint unsigned sq;
        int s, k;
        n[0] = (v[4]-v[1]) * (v[8]-v[2]) - (v[5]-v[2]) * (v[7]-v[1]);
        n[1] = (v[5]-v[2]) * (v[6]-v[0]) - (v[3]-v[0]) * (v[8]-v[2]);
        n[2] = (v[3]-v[0]) * (v[7]-v[1]) - (v[4]-v[1]) * (v[6]-v[0]);
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = n[i] < 0 ? -n[i] : n[i];
            if (a > m)
                m = a;
        end
        if (m == 0)
            return 0;
        s = 0;
        k = 0;
        while ((m >>> s) >= (64'sd1 << 30))
            s++;
        while ((m <<< k) < (64'sd1 << 29))
            k++;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = floor_shr(n[i], s) * (64'sd1 << k);
            sq += longint'(n[i] * n[i]);
        end
        root = root_floor(sq);
        if (root == 0)
            return 0;
        d = -(n[0] * lx + n[1] * ly + n[2] * lz);
        return clamp((d * 2) / root, -32768, 32767);
    endfunction

    // compute and queue the result of one accepted triangle
    function void note_triangle(logic [143:0] tri_in);
        longint v[9];
        longint x, y, z, w, vw, vh, inten;
        logic [176:0] r;
        vw = vp_w > 4096 ? 4096 : vp_w;
        vh = vp_h > 4096 ? 4096 : vp_h;
        for (int i = 0; i < 9; i++)
            v[i] = longint'($signed(tri_in[16*i +: 16]));
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            x = v[3*i];
            y = v[3*i+1];
            z = v[3*i+2];
            if (proj_en)
            begin
                w = 64'sd1073741824 - z * longint'(inv_dist) + 107;
                x = perspective(x, w);
                y = perspective(y, w);
                z = perspective(z, w);
            end
            r[46*i +: 15]      = pixel(x, vw);
            r[46*i + 15 +: 15] = pixel(y, vh);
            r[46*i + 30 +: 16] = 16'(clamp(z, -32768, 32767));
        end
        inten = shade(v);
        r[138 +: 16] = 16'(inten);
        r[176]       = inten > 0;
        pending.push_back(r);
    endfunction

    function void check_result(logic [159:0] td, logic vis);
        logic [176:0] e;
        string names[10];
        int lsb[10], wid[10];
        names = '{"sa_x", "sa_y", "sa_depth", "sb_x", "sb_y", "sb_depth",
                  "sc_x", "sc_y", "sc_depth", "intensity"};
        lsb = '{0, 15, 30, 46, 61, 76, 92, 107, 122, 138};
        wid = '{15, 15, 16, 15, 15, 16, 15, 15, 16, 16};
        if (pending.size() == 0)
        begin
            $error("result with no triangle pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int f = 0; f < 10; f++)
        begin
            logic [15:0] ev, av;
            ev = 16'((e[lsb[f] +: 16]) & ((17'd1 << wid[f]) - 17'd1));
            av = 16'((td[lsb[f] +: 16]) & ((17'd1 << wid[f]) - 17'd1));
            if (ev !== av)
            begin
                $error("%s expected %0h actual %0h", names[f], ev, av);
                errors++;
            end
        end
        if (e[176] !== vis)
        begin
            $error("visible expected %0b actual %0b", e[176], vis);
            errors++;
        end
    endfunction
endclass

module tb_triangle_setup_flat_lighting;
    import tsfl_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // a_x a_y a_z b_x b_y b_z c_x c_y c_z, 16 bits each
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // sa_x sa_y sa_depth sb_x sb_y sb_depth sc_x sc_y sc_depth intensity, padded
    logic [159:0] m_tdata;
    // visible
    logic [0:0]   m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    tri_setup_scoreboard sb;
    int src_idle_pct;   // sender gap chance, percent
    int sink_stall_pct; // receiver stall chance, percent

    triangle_setup_flat_lighting uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: stall pattern changes on the falling edge only
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // check each output transfer at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);

    // one triangle transfer, with an optional random gap in front
    task automatic send_triangle(logic [143:0] t);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = t;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_triangle(t);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // wait until everything expected has come out, then let the pipe settle
    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [15:0] rnd_coord(int mode);
        // mode 0: full range, 1: moderate, 2: extremes
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(24576) - 12288);
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    function automatic logic [143:0] rnd_triangle();
        logic [143:0] t;
        int mode;
        mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(19) == 0 ? 2 : 1);
        for (int i = 0; i < 9; i++)
            t[16*i +: 16] = rnd_coord(mode);
        // sometimes a degenerate one: repeated vertex
        if ($urandom_range(15) == 0)
            t[48 +: 48] = t[0 +: 48];
        return t;
    endfunction

    task automatic random_settings(int pick);
        write_reg(CFG_VIEWPORT_WIDTH, pick == 0 ? 16'd1 : (pick == 1 ? 16'h1fff :
            16'($urandom_range(4096, 1))));
        write_reg(CFG_VIEWPORT_HEIGHT, pick == 0 ? 16'd4096 : (pick == 1 ? 16'd0 :
            16'($urandom_range(8191))));
        write_reg(CFG_LIGHT_X, pick == 1 ? 16'h8000 : 16'($urandom));
        write_reg(CFG_LIGHT_Y, pick == 1 ? 16'h7fff : 16'($urandom));
        write_reg(CFG_LIGHT_Z, pick == 0 ? 16'h7fff : 16'($urandom));
        write_reg(CFG_PROJ_ENABLE, 16'($urandom_range(1)));
        write_reg(CFG_INV_DISTANCE, pick == 0 ? 16'd0 : (pick == 1 ? 16'hffff :
            16'($urandom)));
    endtask

    initial
    begin
        sb             = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_VIEWPORT_WIDTH;
        cfg_data       = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, extremes and degenerate triangles
        send_triangle('0);
        send_triangle({9{16'h7fff}});
        send_triangle({9{16'h8000}});
        send_triangle({16'h0, 16'h0, 16'h4000, 16'h0, 16'h4000, 16'h0,
                       16'h0, 16'h0, 16'h0}); // facing away
        send_triangle({16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000,
                       16'h0, 16'h0, 16'h0}); // facing the light
        send_triangle({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                       16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        drain();
        // projection with w exactly zero: z = 2^30/inv, inv = 2^14 -> z = 65536
        // not reachable, so use inv max with z large for near-zero w
        write_reg(CFG_PROJ_ENABLE, 16'd1);
        write_reg(CFG_INV_DISTANCE, 16'hffff);
        send_triangle({16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                       16'h7fff, 16'h4000, 16'h7fff, 16'h8000});
        send_triangle({16'h0, 16'h0, 16'h4000, 16'h0, 16'h7fff, 16'h0,
                       16'h4000, 16'h1234, 16'h8000});
        drain();
        write_reg(CFG_INV_DISTANCE, 16'h4000);
        // z = 0x7fff gives w close to one half
        send_triangle({16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h7fff,
                       16'h0, 16'h0, 16'h0});
        drain();
        random_settings(0);
        for (int i = 0; i < 8; i++)
            send_triangle(rnd_triangle());
        drain();
        random_settings(1);
        for (int i = 0; i < 8; i++)
            send_triangle(rnd_triangle());
        drain();

        // random phases over the idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            random_settings(2);
            for (int i = 0; i < 55; i++)
            begin
                send_triangle(rnd_triangle());
                // hold off until the pipe is empty, once per phase
                if (i == 25)
                    while (sb.pending.size() != 0)
                        @(negedge clk);
            end
            drain();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
